// ===== rtl/tep_pkg.sv =====
`default_nettype none

package tep_pkg;

	localparam int ARG_CHARS_DEF = 5;

	localparam int BYTE_W = 8;
	localparam int CMD_W  = 6;
	localparam int ARG_W  = 14;
	localparam int OUT_W  = CMD_W + BYTE_W + 2 * ARG_W;
	localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

	localparam logic [ARG_W-1:0] ARG_MAX = ARG_W'(9999);

	localparam logic [BYTE_W-1:0] CH_ESC   = 8'h1B;
	localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
	localparam logic [BYTE_W-1:0] CH_TILDE = 8'h7E;
	localparam logic [BYTE_W-1:0] CH_SEMI  = 8'h3B;
	localparam logic [BYTE_W-1:0] CH_FS    = 8'h1C;
	localparam logic [BYTE_W-1:0] CH_GS    = 8'h1D;
	localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;

	localparam logic [CMD_W-1:0] CMD_NONE    = 6'd0;
	localparam logic [CMD_W-1:0] CMD_PRINT   = 6'd0;
	localparam logic [CMD_W-1:0] CMD_BELL    = 6'd1;
	localparam logic [CMD_W-1:0] CMD_BS      = 6'd2;
	localparam logic [CMD_W-1:0] CMD_TAB     = 6'd3;
	localparam logic [CMD_W-1:0] CMD_NL      = 6'd4;
	localparam logic [CMD_W-1:0] CMD_CLEAR   = 6'd5;
	localparam logic [CMD_W-1:0] CMD_CR      = 6'd6;
	localparam logic [CMD_W-1:0] CMD_RESTORE = 6'd7;
	localparam logic [CMD_W-1:0] CMD_SAVE    = 6'd8;
	localparam logic [CMD_W-1:0] CMD_MOVE    = 6'd37;
	localparam logic [CMD_W-1:0] CMD_REGION  = 6'd38;
	localparam logic [CMD_W-1:0] CMD_LAST    = 6'd38;

	typedef struct packed {
		logic             valid;
		logic [CMD_W-1:0] command;
		logic [BYTE_W-1:0] char_out;
		logic [ARG_W-1:0] column;
		logic [ARG_W-1:0] row;
	} result_t;

	function automatic logic [CMD_W-1:0] base_cmd(input logic [BYTE_W-1:0] b);
		logic [CMD_W-1:0] c;
		case (b)
			8'h07:        c = CMD_BELL;
			8'h08:        c = CMD_BS;
			8'h09:        c = CMD_TAB;
			8'h0A:        c = CMD_NL;
			8'h0B, 8'h0C: c = CMD_CLEAR;
			8'h0D:        c = CMD_CR;
			CH_FS:        c = CMD_RESTORE;
			CH_GS:        c = CMD_SAVE;
			default:      c = CMD_NONE;
		endcase
		return c;
	endfunction

	function automatic logic [CMD_W-1:0] esc_cmd(input logic [BYTE_W-1:0] b);
		logic [CMD_W-1:0] c;
		case (b)
			"A":     c = 6'd9;
			"B":     c = 6'd10;
			"C":     c = 6'd11;
			"F":     c = 6'd12;
			"K":     c = 6'd13;
			"P":     c = 6'd14;
			"R":     c = 6'd15;
			"T":     c = 6'd16;
			"U":     c = 6'd17;
			"V":     c = 6'd18;
			"W":     c = 6'd19;
			"X":     c = 6'd20;
			"Y":     c = 6'd21;
			"Z":     c = 6'd22;
			default: c = CMD_NONE;
		endcase
		return c;
	endfunction

	function automatic logic [CMD_W-1:0] o_cmd(input logic [BYTE_W-1:0] b);
		logic [CMD_W-1:0] c;
		case (b)
			"i":     c = 6'd23;
			"b":     c = 6'd24;
			"d":     c = 6'd25;
			"r":     c = 6'd26;
			"l":     c = 6'd27;
			"o":     c = 6'd28;
			"t":     c = 6'd29;
			"u":     c = 6'd30;
			default: c = CMD_NONE;
		endcase
		return c;
	endfunction

	function automatic logic [CMD_W-1:0] n_cmd(input logic [BYTE_W-1:0] b);
		logic [CMD_W-1:0] c;
		case (b)
			"i":     c = 6'd31;
			"l":     c = 6'd32;
			"*":     c = 6'd33;
			"o":     c = 6'd34;
			"t":     c = 6'd35;
			"u":     c = 6'd36;
			default: c = CMD_NONE;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/tep_parse.sv =====
`default_nettype none

module tep_parse import tep_pkg::*; #(
	parameter int ARG_CHARS = ARG_CHARS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              step_en,
	input  wire logic [BYTE_W-1:0] byte_in,
	output result_t                res
);

	localparam int CNT_W = $clog2(ARG_CHARS);
	localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(ARG_CHARS - 1);

	typedef enum logic [2:0] {
		M_BASE, M_ESC, M_N, M_O, M_E1, M_E2, M_CM1, M_CM2
	} mode_t;

	mode_t            mode_q, mode_d;
	logic [ARG_W-1:0] arg1_q, arg1_d, arg2_q, arg2_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;

	logic             is_digit;
	logic [3:0]       dval;
	logic             cnt_full;
	logic [CMD_W-1:0] cmd_tmp;

	// acc * 10 + d, saturated
	function automatic logic [ARG_W-1:0] acc_digit(input logic [ARG_W-1:0] acc,
			input logic [3:0] d);
		logic [ARG_W+3:0] v;
		v = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + (ARG_W+4)'(d);
		return (v > (ARG_W+4)'(ARG_MAX)) ? ARG_MAX : v[ARG_W-1:0];
	endfunction

	assign is_digit = (byte_in >= CH_ZERO) && (byte_in <= CH_NINE);
	assign dval     = 4'(byte_in - CH_ZERO);
	assign cnt_full = (cnt_q >= CNT_LIMIT);

	always_comb begin
		mode_d  = mode_q;
		arg1_d  = arg1_q;
		arg2_d  = arg2_q;
		cnt_d   = cnt_q;
		cmd_tmp = CMD_NONE;
		res     = '0;
		case (mode_q)
			M_BASE: begin
				if (byte_in >= CH_SPACE && byte_in <= CH_TILDE) begin
					res.valid    = 1'b1;
					res.command  = CMD_PRINT;
					res.char_out = byte_in;
				end else if (byte_in == CH_ESC) begin
					mode_d = M_ESC;
				end else begin
					cmd_tmp = base_cmd(byte_in);
					res.valid   = (cmd_tmp != CMD_NONE);
					res.command = cmd_tmp;
				end
			end
			M_ESC: begin
				arg1_d = '0;
				arg2_d = '0;
				cnt_d  = '0;
				if (byte_in == "E") begin
					mode_d = M_E1;
				end else if (byte_in == "N") begin
					mode_d = M_N;
				end else if (byte_in == "O") begin
					mode_d = M_O;
				end else if (is_digit) begin
					arg1_d = ARG_W'(dval);
					cnt_d  = CNT_W'(1);
					mode_d = M_CM1;
				end else if (byte_in == CH_SEMI) begin
					mode_d = M_CM2;
				end else begin
					mode_d  = M_BASE;
					cmd_tmp = esc_cmd(byte_in);
					res.valid   = (cmd_tmp != CMD_NONE);
					res.command = cmd_tmp;
				end
			end
			M_N: begin
				mode_d  = M_BASE;
				cmd_tmp = n_cmd(byte_in);
				res.valid   = (cmd_tmp != CMD_NONE);
				res.command = cmd_tmp;
			end
			M_O: begin
				mode_d  = M_BASE;
				cmd_tmp = o_cmd(byte_in);
				res.valid   = (cmd_tmp != CMD_NONE);
				res.command = cmd_tmp;
			end
			M_E1, M_CM1: begin
				if (is_digit) begin
					if (cnt_full) begin
						mode_d = M_BASE;
					end else begin
						arg1_d = acc_digit(arg1_q, dval);
						cnt_d  = cnt_q + CNT_W'(1);
					end
				end else if (byte_in == CH_SEMI) begin
					cnt_d  = '0;
					mode_d = (mode_q == M_E1) ? M_E2 : M_CM2;
				end else begin
					mode_d = M_BASE;
				end
			end
			M_E2, M_CM2: begin
				if (is_digit) begin
					if (cnt_full) begin
						mode_d = M_BASE;
					end else begin
						arg2_d = acc_digit(arg2_q, dval);
						cnt_d  = cnt_q + CNT_W'(1);
					end
				end else if (byte_in == CH_SEMI) begin
					mode_d      = M_BASE;
					res.valid   = 1'b1;
					res.command = (mode_q == M_E2) ? CMD_REGION : CMD_MOVE;
					res.column  = arg2_q;
					res.row     = arg1_q;
				end else begin
					mode_d = M_BASE;
				end
			end
			default: begin
				mode_d = M_BASE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_BASE;
			arg1_q <= '0;
			arg2_q <= '0;
			cnt_q  <= '0;
		end else if (step_en) begin
			mode_q <= mode_d;
			arg1_q <= arg1_d;
			arg2_q <= arg2_d;
			cnt_q  <= cnt_d;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/terminal_escape_parser.sv =====
// An accepted byte passes the input register and then the output register before its result shows on m_tvalid.
// One item per cycle while m_tready does not stall the output; each byte needs one update of the mode register.
// A result waiting at the output lets the input register still fill once.
// Reset: arst_n clears the pipeline valids, the parse mode (base mode),
// both argument accumulators and the digit count, asynchronously.
`default_nettype none

module terminal_escape_parser import tep_pkg::*; #(
	parameter int ARG_CHARS = ARG_CHARS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	input  wire logic [7:0]             s_tdata,  // [7:0] byte_in
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	// [5:0] command, [13:6] char_out, [27:14] column, [41:28] row, rest zero
	output logic [OUT_TDATA_W-1:0]      m_tdata
);

	// Input register: one byte waiting for the parser.
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;

	// Output register: one finished result.
	logic              out_valid_q;
	result_t           out_q;

	result_t           res;
	logic              advance;
	logic              step_en;

	// Move the input stage forward whenever the output slot is free or drains now.
	assign advance  = !out_valid_q || m_tready;
	assign step_en  = valid_s1 && advance;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// Capture the byte on every open slot; valid_s1 qualifies it.
	always_ff @(posedge clk) begin
		if (s_tready) begin
			byte_s1 <= s_tdata;
		end
	end

	// Parser: mode and accumulators step only when the held byte is consumed.
	tep_parse #(
		.ARG_CHARS (ARG_CHARS)
	) u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (step_en),
		.byte_in (byte_s1),
		.res     (res)
	);

	// Load a result only for bytes that yield one; drop the slot otherwise.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1 && res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en && res.valid) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_TDATA_W'({out_q.row, out_q.column, out_q.char_out, out_q.command});

`ifndef SYNTHESIS
	// A byte held in the input stage must not change while the parser waits.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(byte_s1))
		else $error("input stage lost its byte while stalled");

	// Only known command codes leave the block.
	a_cmd_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_q.command <= CMD_LAST)
		else $error("command code out of range");

	// char_out is set only for print commands.
	a_char_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.command != CMD_PRINT |-> out_q.char_out == '0)
		else $error("char_out set on a non-print command");

	// Arguments appear only on cursor move and scroll region, and stay saturated.
	a_args: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ((out_q.command == CMD_MOVE || out_q.command == CMD_REGION) ?
			(out_q.column <= ARG_MAX && out_q.row <= ARG_MAX) :
			(out_q.column == '0 && out_q.row == '0)))
		else $error("argument fields inconsistent with command");
`endif

endmodule

`default_nettype wire

// ===== test/terminal_escape_parser_tb.sv =====
`timescale 1ns / 100ps

module terminal_escape_parser_tb;
	import tep_pkg::*;

	// Control bytes of the base mode and the letters that open sub-modes
	localparam logic [7:0] CH_BEL = 8'h07;
	localparam logic [7:0] CH_BS  = 8'h08;
	localparam logic [7:0] CH_HT  = 8'h09;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_VT  = 8'h0B;
	localparam logic [7:0] CH_FF  = 8'h0C;
	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_E   = "E";
	localparam logic [7:0] CH_N   = "N";
	localparam logic [7:0] CH_O   = "O";

	// Command letter tables: the code of a letter is the table base plus its slot
	localparam int TBL_W = 8 * 14;
	localparam logic [TBL_W-1:0] ESC_LETTERS = "ABCFKPRTUVWXYZ";
	localparam logic [TBL_W-1:0] O_LETTERS   = "ibdrlotu";
	localparam logic [TBL_W-1:0] N_LETTERS   = "il*otu";
	localparam int ESC_COUNT = 14;
	localparam int O_COUNT   = 8;
	localparam int N_COUNT   = 6;
	localparam logic [CMD_W-1:0] CMD_ESC_FIRST = 6'd9;
	localparam logic [CMD_W-1:0] CMD_O_FIRST   = 6'd23;
	localparam logic [CMD_W-1:0] CMD_N_FIRST   = 6'd31;

	localparam int ARG_DIGITS   = ARG_CHARS_DEF;
	localparam int RANDOM_ITEMS = 580;
	localparam int HOLD_CYCLES  = 120;
	localparam int STALL_LIMIT  = 3000;
	localparam int DRAIN_CYCLES = 20;
	localparam int PRINT_CAP    = 40;

	typedef enum logic [2:0] {
		PS_BASE, PS_ESC, PS_N, PS_O, PS_REGION_ROW, PS_REGION_COL, PS_MOVE_ROW, PS_MOVE_COL
	} parse_state_t;

	typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_CADENCE} rx_style_t;

	typedef struct packed {
		logic [CMD_W-1:0]  command;
		logic [BYTE_W-1:0] char_out;
		logic [ARG_W-1:0]  column;
		logic [ARG_W-1:0]  row;
	} term_cmd_t;

	logic                   clk;
	logic                   arst_n   = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [7:0]             s_tdata  = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;

	// Parser shadow state
	parse_state_t   parse_state;
	logic [ARG_W-1:0] row_arg;
	logic [ARG_W-1:0] col_arg;
	int             digits_in_arg;
	term_cmd_t      pending_cmds[$];

	int error_count     = 0;
	int accepted_items  = 0;
	int useful_items    = 0;
	int results_checked = 0;
	int burst_left      = 0;
	int idle_cycles     = 0;
	logic hold_toggle   = 1'b0;

	terminal_escape_parser #(.ARG_CHARS(ARG_DIGITS)) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic report_error(input string msg);
		error_count++;
		if (error_count <= PRINT_CAP)
			$display("[%0t] ERROR: %s", $realtime, msg);
	endtask

	function automatic logic [7:0] table_char(input logic [TBL_W-1:0] tbl, input int len,
			input int k);
		return tbl[8*(len-1-k) +: 8];
	endfunction

	function automatic int table_slot(input logic [TBL_W-1:0] tbl, input int len,
			input logic [7:0] b);
		for (int k = 0; k < len; k++)
			if (table_char(tbl, len, k) == b)
				return k;
		return -1;
	endfunction

	function automatic logic [ARG_W-1:0] add_digit(input logic [ARG_W-1:0] acc,
			input logic [7:0] b);
		int v;
		v = acc * 10 + (b - CH_ZERO);
		return (v > ARG_MAX) ? ARG_MAX : v[ARG_W-1:0];
	endfunction

	// Advance the shadow parser by one byte and queue the command it yields.
	// Return 0 only for a byte that the base mode drops without effect.
	function automatic bit parse_byte(input logic [7:0] b);
		term_cmd_t        r;
		bit               emit;
		bit               digit;
		bit               ignored;
		int               slot;
		logic [CMD_W-1:0] c;
		r       = '0;
		emit    = 1'b0;
		ignored = 1'b0;
		digit   = (b >= CH_ZERO) && (b <= CH_NINE);
		case (parse_state)
			PS_BASE: begin
				if (b >= CH_SPACE && b <= CH_TILDE) begin
					emit       = 1'b1;
					r.command  = CMD_PRINT;
					r.char_out = b;
				end else if (b == CH_ESC) begin
					parse_state = PS_ESC;
				end else begin
					case (b)
						CH_BEL:       c = CMD_BELL;
						CH_BS:        c = CMD_BS;
						CH_HT:        c = CMD_TAB;
						CH_LF:        c = CMD_NL;
						CH_VT, CH_FF: c = CMD_CLEAR;
						CH_CR:        c = CMD_CR;
						CH_FS:        c = CMD_RESTORE;
						CH_GS:        c = CMD_SAVE;
						default:      c = CMD_NONE;
					endcase
					emit      = (c != CMD_NONE);
					ignored   = !emit;
					r.command = c;
				end
			end
			PS_ESC: begin
				row_arg       = '0;
				col_arg       = '0;
				digits_in_arg = 0;
				if (b == CH_E) begin
					parse_state = PS_REGION_ROW;
				end else if (b == CH_N) begin
					parse_state = PS_N;
				end else if (b == CH_O) begin
					parse_state = PS_O;
				end else if (digit) begin
					row_arg       = add_digit('0, b);
					digits_in_arg = 1;
					parse_state   = PS_MOVE_ROW;
				end else if (b == CH_SEMI) begin
					// ESC ';' skips straight to the column argument
					parse_state = PS_MOVE_COL;
				end else begin
					parse_state = PS_BASE;
					slot        = table_slot(ESC_LETTERS, ESC_COUNT, b);
					emit        = (slot >= 0);
					r.command   = CMD_W'(CMD_ESC_FIRST + slot);
				end
			end
			PS_N, PS_O: begin
				slot = (parse_state == PS_N) ? table_slot(N_LETTERS, N_COUNT, b)
				                             : table_slot(O_LETTERS, O_COUNT, b);
				emit      = (slot >= 0);
				r.command = (parse_state == PS_N) ? CMD_W'(CMD_N_FIRST + slot)
				                                  : CMD_W'(CMD_O_FIRST + slot);
				parse_state = PS_BASE;
			end
			PS_REGION_ROW, PS_MOVE_ROW: begin
				if (digit) begin
					// one digit too many drops the whole sequence
					if (digits_in_arg >= ARG_DIGITS - 1) begin
						parse_state = PS_BASE;
					end else begin
						row_arg = add_digit(row_arg, b);
						digits_in_arg++;
					end
				end else if (b == CH_SEMI) begin
					digits_in_arg = 0;
					parse_state   = (parse_state == PS_REGION_ROW) ? PS_REGION_COL : PS_MOVE_COL;
				end else begin
					parse_state = PS_BASE;
				end
			end
			default: begin
				if (digit) begin
					if (digits_in_arg >= ARG_DIGITS - 1) begin
						parse_state = PS_BASE;
					end else begin
						col_arg = add_digit(col_arg, b);
						digits_in_arg++;
					end
				end else begin
					if (b == CH_SEMI) begin
						emit      = 1'b1;
						r.command = (parse_state == PS_REGION_COL) ? CMD_REGION : CMD_MOVE;
						r.column  = col_arg;
						r.row     = row_arg;
					end
					parse_state = PS_BASE;
				end
			end
		endcase
		if (emit)
			pending_cmds.push_back(r);
		return !ignored;
	endfunction

	// Offer one item, honoring the burst/gap pattern, and hold it until taken
	task automatic send_byte(input logic [7:0] b);
		int gap;
		if (burst_left == 0) begin
			gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			burst_left = $urandom_range(1, 32);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		accepted_items++;
		if (parse_byte(b))
			useful_items++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	task automatic send_digits(input int count);
		bool_nines: begin
			bit nines;
			nines = ($urandom_range(0, 3) == 0);
			for (int i = 0; i < count; i++)
				send_byte(nines ? CH_NINE : 8'(CH_ZERO + $urandom_range(0, 9)));
		end
	endtask

	// Scroll region or cursor move with random argument lengths; a row of
	// zero digits on a cursor move starts with ESC ';' directly
	task automatic send_arg_form(input bit region);
		int n_row;
		int n_col;
		n_row = ($urandom_range(0, 15) == 0) ? ARG_DIGITS : $urandom_range(0, ARG_DIGITS - 1);
		n_col = ($urandom_range(0, 15) == 0) ? ARG_DIGITS : $urandom_range(0, ARG_DIGITS - 1);
		send_byte(CH_ESC);
		if (region)
			send_byte(CH_E);
		send_digits(n_row);
		send_byte(CH_SEMI);
		send_digits(n_col);
		send_byte(($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) : CH_SEMI);
	endtask

	task automatic test_base_bytes();
		// print extremes, dropped bytes around them, every control command
		send_byte(CH_SPACE);
		send_byte(CH_TILDE);
		send_byte(8'h00);
		send_byte(8'h1F);
		send_byte(8'h7F);
		send_byte(8'h80);
		send_byte(8'hFF);
		send_byte(CH_BEL);
		send_byte(CH_BS);
		send_byte(CH_HT);
		send_byte(CH_LF);
		send_byte(CH_VT);
		send_byte(CH_FF);
		send_byte(CH_CR);
		send_byte(CH_FS);
		send_byte(CH_GS);
	endtask

	task automatic test_escape_table();
		for (int k = 0; k < ESC_COUNT; k++) begin
			send_byte(CH_ESC);
			send_byte(table_char(ESC_LETTERS, ESC_COUNT, k));
		end
		for (int k = 0; k < O_COUNT; k++) begin
			send_byte(CH_ESC);
			send_byte(CH_O);
			send_byte(table_char(O_LETTERS, O_COUNT, k));
		end
		for (int k = 0; k < N_COUNT; k++) begin
			send_byte(CH_ESC);
			send_byte(CH_N);
			send_byte(table_char(N_LETTERS, N_COUNT, k));
		end
	endtask

	task automatic test_argument_forms();
		// largest arguments
		send_byte(CH_ESC);
		send_text("E9999;9999;");
		// smallest, then empty arguments on both forms
		send_byte(CH_ESC);
		send_text("0;0;");
		send_byte(CH_ESC);
		send_text(";;");
		send_byte(CH_ESC);
		send_text("E;;");
		send_byte(CH_ESC);
		send_text("7;42;");
		// fifth digit aborts, the tail then prints in base mode
		send_byte(CH_ESC);
		send_text("12345;6;");
		send_byte(CH_ESC);
		send_text("E3;12345;");
		// unexpected bytes after ESC, ESC N, ESC O and in a region row fall back silently
		send_byte(CH_ESC);
		send_text("E12x");
		send_byte(CH_ESC);
		send_text("N?");
		send_byte(CH_ESC);
		send_text("Q");
		send_byte(CH_ESC);
		send_byte(CH_O);
		send_byte(CH_ESC);
		send_byte(CH_ESC);
		send_text("5;9z");
	endtask

	task automatic test_output_stall();
		// stall the output long enough for the block to refuse input
		hold_toggle <= ~hold_toggle;
		for (int i = 0; i < 40; i++)
			send_byte(8'($urandom_range(CH_SPACE, CH_TILDE)));
		send_arg_form(1'b0);
		send_arg_form(1'b1);
	endtask

	task automatic test_random_stream();
		int pick;
		int run;
		useful_items = 0;
		while (useful_items < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 11);
			case (pick)
				0, 1: begin
					run = $urandom_range(1, 8);
					repeat (run) send_byte(8'($urandom_range(CH_SPACE, CH_TILDE)));
				end
				2: begin
					case ($urandom_range(0, 8))
						0:       send_byte(CH_BEL);
						1:       send_byte(CH_BS);
						2:       send_byte(CH_HT);
						3:       send_byte(CH_LF);
						4:       send_byte(CH_VT);
						5:       send_byte(CH_FF);
						6:       send_byte(CH_CR);
						7:       send_byte(CH_FS);
						default: send_byte(CH_GS);
					endcase
				end
				3: send_byte(8'($urandom_range(0, 255)));
				4: begin
					send_byte(CH_ESC);
					send_byte(table_char(ESC_LETTERS, ESC_COUNT, $urandom_range(0, ESC_COUNT - 1)));
				end
				5: begin
					send_byte(CH_ESC);
					send_byte(CH_O);
					send_byte(($urandom_range(0, 5) == 0) ? 8'($urandom_range(0, 255))
					          : table_char(O_LETTERS, O_COUNT, $urandom_range(0, O_COUNT - 1)));
				end
				6: begin
					send_byte(CH_ESC);
					send_byte(CH_N);
					send_byte(($urandom_range(0, 5) == 0) ? 8'($urandom_range(0, 255))
					          : table_char(N_LETTERS, N_COUNT, $urandom_range(0, N_COUNT - 1)));
				end
				7, 8:  send_arg_form(1'b0);
				9, 10: send_arg_form(1'b1);
				default: begin
					send_byte(CH_ESC);
					send_byte(8'($urandom_range(0, 255)));
				end
			endcase
		end
	endtask

	// Receiver: switch between open, random and cadenced stalls; a toggle of
	// hold_toggle starts a long hold counted here
	always @(posedge clk) begin
		static logic      hold_seen  = 1'b0;
		static int        hold_left  = 0;
		static int        style_left = 0;
		static rx_style_t rx_style   = RX_OPEN;
		if (hold_toggle != hold_seen) begin
			hold_seen = hold_toggle;
			hold_left = HOLD_CYCLES;
		end
		if (style_left == 0) begin
			rx_style   = rx_style_t'($urandom_range(0, 2));
			style_left = $urandom_range(16, 96);
		end
		style_left--;
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			case (rx_style)
				RX_OPEN:   m_tready <= 1'b1;
				RX_RANDOM: m_tready <= ($urandom_range(0, 9) > 3);
				default:   m_tready <= (style_left % 3 != 0);
			endcase
		end
	end

	// Compare each accepted result with the oldest expectation
	always @(posedge clk) begin
		term_cmd_t want;
		if (arst_n && m_tvalid && m_tready) begin
			results_checked++;
			if (pending_cmds.size() == 0) begin
				report_error($sformatf("result with nothing expected, command %0d",
				             m_tdata[CMD_W-1:0]));
			end else begin
				want = pending_cmds.pop_front();
				if (m_tdata[CMD_W-1:0] != want.command)
					report_error($sformatf("command got %0d expected %0d",
					             m_tdata[CMD_W-1:0], want.command));
				if (m_tdata[CMD_W +: BYTE_W] != want.char_out)
					report_error($sformatf("char_out got %0h expected %0h",
					             m_tdata[CMD_W +: BYTE_W], want.char_out));
				if (m_tdata[CMD_W+BYTE_W +: ARG_W] != want.column)
					report_error($sformatf("column got %0d expected %0d",
					             m_tdata[CMD_W+BYTE_W +: ARG_W], want.column));
				if (m_tdata[CMD_W+BYTE_W+ARG_W +: ARG_W] != want.row)
					report_error($sformatf("row got %0d expected %0d",
					             m_tdata[CMD_W+BYTE_W+ARG_W +: ARG_W], want.row));
				if (m_tdata[OUT_TDATA_W-1:OUT_W] != '0)
					report_error($sformatf("padding bits not zero: %0h",
					             m_tdata[OUT_TDATA_W-1:OUT_W]));
			end
		end
	end

	// Watchdog: end the run when neither side moves for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Timeout: no item moved for %0d cycles", STALL_LIMIT);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		parse_state   = PS_BASE;
		row_arg       = '0;
		col_arg       = '0;
		digits_in_arg = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_base_bytes();
		test_escape_table();
		test_argument_forms();
		test_output_stall();
		test_random_stream();
		s_tvalid <= 1'b0;

		while (pending_cmds.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d bytes: base and control bytes, full escape tables,", accepted_items);
		$display("argument forms with aborts, a %0d-cycle output stall; %0d commands checked",
		         HOLD_CYCLES, results_checked);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/tep_pkg.sv
rtl/tep_parse.sv
rtl/terminal_escape_parser.sv
test/terminal_escape_parser_tb.sv
